FILE: sv/cluster_window_match_combine_macros.svh
// Assertion macros shared by the cluster window match and combine RTL.
`ifndef CLUSTER_WINDOW_MATCH_COMBINE_MACROS_SVH
`define CLUSTER_WINDOW_MATCH_COMBINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define CWMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define CWMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cwmc_pkg.sv
// Types and constants of the cluster window match and combine block.
package cwmc_pkg;

  localparam int unsigned MaxClustersDef = 32;

  localparam int unsigned RtW    = 32;
  localparam int unsigned MzW    = 32;
  localparam int unsigned InW    = 40;
  localparam int unsigned CombW  = 48;
  localparam int unsigned ScaleW = 24;

  typedef enum logic [1:0] {
    ActLoadCtl = 2'd0,
    ActLoadTrt = 2'd1,
    ActRun     = 2'd2,
    ActClear   = 2'd3
  } action_e;

  // Register indexes, byte address is four times the index.
  localparam logic [1:0] RegRtTol = 2'd0;
  localparam logic [1:0] RegMzTol = 2'd1;
  localparam logic [1:0] RegMode  = 2'd2;
  localparam logic [1:0] RegScale = 2'd3;

  // Combine modes; any other code subtracts.
  localparam logic [1:0] ModeMerge = 2'd0;
  localparam logic [1:0] ModeRatio = 2'd1;

  localparam logic [ScaleW-1:0] ScaleReset = 24'h01_0000;
  localparam logic [47:0]       OneQ16     = 48'h0000_0001_0000;
  localparam logic [47:0]       SatHiU     = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SatHi50   = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SatLo50   = 50'sh3_8000_0000_0000;

  typedef struct packed {
    logic [RtW-1:0] rt;
    logic [MzW-1:0] mz;
    logic [InW-1:0] inten;
  } entry_t;

  typedef struct packed {
    action_e        action;
    logic [RtW-1:0] retention_time;
    logic [MzW-1:0] mass_to_charge;
    logic [InW-1:0] peak_intensity;
  } in_item_t;

  typedef struct packed {
    logic [RtW-1:0]          query_rt;
    logic [MzW-1:0]          query_mz;
    logic signed [CombW-1:0] combined_value;
    logic [InW-1:0]          control_mean;
    logic [InW-1:0]          treatment_mean;
    logic                    nonzero;
    logic                    last_result;
    logic                    table_full;
  } out_item_t;

endpackage

FILE: sv/cluster_window_match_combine.sv
// Top level of the cluster window match and combine block.
// Loads and clears complete in the idle state; a load into a full table returns one request.
// A run query steps through search, output (which may stall), fetch, a scan over the
// larger table count, two divisions, multiply and combine; ratio mode adds a third
// division on the shared divider; up to 2*MAX_CLUSTERS queries, input held off.
// Reset (asynchronous, active low) empties both tables and loads register defaults.
`include "cluster_window_match_combine_macros.svh"

module cluster_window_match_combine #(
  parameter int unsigned MAX_CLUSTERS = cwmc_pkg::MaxClustersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cwmc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cwmc_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cwmc_pkg::*;

  // Table index, count and sum widths follow the table depth; the divider widths are fixed.
  localparam int unsigned IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CW  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned SW  = InW + CW;
  localparam int unsigned DW  = 64;
  localparam int unsigned RW  = InW + 1;
  localparam logic [CW-1:0] CntMax = CW'(MAX_CLUSTERS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NEXT   = 4'd1;
  localparam logic [3:0] S_QFETCH = 4'd2;
  localparam logic [3:0] S_QDATA  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DIVC   = 4'd5;
  localparam logic [3:0] S_DIVT   = 4'd6;
  localparam logic [3:0] S_MUL1   = 4'd7;
  localparam logic [3:0] S_MUL2   = 4'd8;
  localparam logic [3:0] S_COMB   = 4'd9;
  localparam logic [3:0] S_DIVR   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  function automatic logic in_box(entry_t e, logic [RtW-1:0] qrt, logic [MzW-1:0] qmz,
                                  logic [RtW-1:0] tolr, logic [MzW-1:0] tolm);
    logic [RtW-1:0] dr;
    logic [MzW-1:0] dm;
    dr = (e.rt >= qrt) ? e.rt - qrt : qrt - e.rt;
    dm = (e.mz >= qmz) ? e.mz - qmz : qmz - e.mz;
    return (dr <= tolr) && (dm <= tolm);
  endfunction

  // Configuration registers.
  logic [RtW-1:0]    rt_tol_q;
  logic [MzW-1:0]    mz_tol_q;
  logic [1:0]        mode_q;
  logic [ScaleW-1:0] scale_q;

  // Cluster tables with one registered read port each.
  entry_t ctl_mem [MAX_CLUSTERS];
  entry_t trt_mem [MAX_CLUSTERS];
  entry_t ctl_rd_q, trt_rd_q;
  logic [IW-1:0] raddr;

  logic [CW-1:0]           cc_q, tc_q;
  logic [MAX_CLUSTERS-1:0] cons_q;

  logic [3:0]     state_q;
  logic           qsel_q;
  logic [CW-1:0]  qi_q;
  logic [RtW-1:0] qrt_q;
  logic [MzW-1:0] qmz_q;
  logic           have_q, fetch_q;

  logic [CW-1:0] scan_q, pj_q, nmax;
  logic          pv_q;
  logic [SW-1:0] csum_q, tsum_q;
  logic [CW-1:0] cn_q, tn_q;

  // Shared restoring divider: one quotient bit per cycle.
  logic [DW-1:0]  dvd_q;
  logic [RW-1:0]  rem_q, rem_sh;
  logic [InW-1:0] dvs_q;
  logic [6:0]     it_q;
  logic           div_ge;

  logic [InW-1:0]          cm_q, tm_q;
  logic [DW-1:0]           p_q;
  logic [19:0]             mul_a;
  logic [43:0]             prod;
  logic [47:0]             s_val, num;
  logic [InW-1:0]          den;
  logic signed [49:0]      v50;
  logic signed [CombW-1:0] comb_sat;
  out_item_t               out_q;

  logic in_fire, cfg_we, ctl_hit, trt_hit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegRtTol: prdata = rt_tol_q;
      RegMzTol: prdata = mz_tol_q;
      RegMode:  prdata = {30'b0, mode_q};
      RegScale: prdata = {8'b0, scale_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_tol_q <= '0;
      mz_tol_q <= '0;
      mode_q   <= ModeMerge;
      scale_q  <= ScaleReset;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegRtTol: rt_tol_q <= pwdata;
        RegMzTol: mz_tol_q <= pwdata;
        RegMode:  mode_q   <= pwdata[1:0];
        RegScale: scale_q  <= pwdata[ScaleW-1:0];
        default:  ;
      endcase
    end
  end

  // During a scan both tables are read at the scan index, otherwise at the query index.
  assign raddr = (state_q == S_SCAN) ? scan_q[IW-1:0] : qi_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.action == ActLoadCtl && cc_q != CntMax) begin
      ctl_mem[cc_q[IW-1:0]] <= {in_data_i.retention_time, in_data_i.mass_to_charge,
                                in_data_i.peak_intensity};
    end
    ctl_rd_q <= ctl_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.action == ActLoadTrt && tc_q != CntMax) begin
      trt_mem[tc_q[IW-1:0]] <= {in_data_i.retention_time, in_data_i.mass_to_charge,
                                in_data_i.peak_intensity};
    end
    trt_rd_q <= trt_mem[raddr];
  end

  assign nmax    = (cc_q > tc_q) ? cc_q : tc_q;
  assign ctl_hit = pv_q && (pj_q < cc_q) && in_box(ctl_rd_q, qrt_q, qmz_q, rt_tol_q, mz_tol_q);
  assign trt_hit = pv_q && (pj_q < tc_q) && in_box(trt_rd_q, qrt_q, qmz_q, rt_tol_q, mz_tol_q);

  assign rem_sh = {rem_q[RW-2:0], dvd_q[DW-1]};
  assign div_ge = rem_sh >= {1'b0, dvs_q};

  // One 20 by 24 bit multiplier covers the 40 bit mean in two halves.
  assign mul_a = (state_q == S_MUL1) ? tm_q[19:0] : tm_q[39:20];
  assign prod  = mul_a * scale_q;
  assign s_val = p_q[63:16];
  assign num   = (s_val < OneQ16) ? OneQ16 : s_val;
  assign den   = (cm_q < OneQ16[InW-1:0]) ? OneQ16[InW-1:0] : cm_q;

  always_comb begin
    if (mode_q == ModeMerge) begin
      v50 = $signed({2'b0, s_val}) + $signed({10'b0, cm_q});
    end else begin
      v50 = $signed({2'b0, s_val}) - $signed({10'b0, cm_q});
    end
    priority if (v50 > SatHi50) begin
      comb_sat = SatHiU;
    end else if (v50 < SatLo50) begin
      comb_sat = SatLo50[CombW-1:0];
    end else begin
      comb_sat = v50[CombW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cc_q    <= '0;
      tc_q    <= '0;
      cons_q  <= '0;
      qsel_q  <= 1'b0;
      qi_q    <= '0;
      have_q  <= 1'b0;
      fetch_q <= 1'b0;
      scan_q  <= '0;
      pj_q    <= '0;
      pv_q    <= 1'b0;
      it_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data_i.action)
              ActLoadCtl, ActLoadTrt: begin
                if (in_data_i.action == ActLoadCtl && cc_q != CntMax) begin
                  cc_q <= cc_q + 1'b1;
                end else if (in_data_i.action == ActLoadTrt && tc_q != CntMax) begin
                  tc_q <= tc_q + 1'b1;
                end else begin
                  // Dropped load: a request with only the full flag set.
                  out_q   <= '{table_full: 1'b1, default: '0};
                  fetch_q <= 1'b0;
                  state_q <= S_OUT;
                end
              end
              ActRun: begin
                cons_q  <= '0;
                qsel_q  <= 1'b0;
                qi_q    <= '0;
                have_q  <= 1'b0;
                state_q <= S_NEXT;
              end
              ActClear: begin
                cc_q   <= '0;
                tc_q   <= '0;
                cons_q <= '0;
              end
              default: ;
            endcase
          end
        end
        // Look for the next query; a finished result waits until we know
        // whether it is the last of the run.
        S_NEXT: begin
          if (!qsel_q && qi_q >= cc_q) begin
            qsel_q <= 1'b1;
            qi_q   <= '0;
          end else if (qsel_q && qi_q < tc_q && cons_q[qi_q[IW-1:0]]) begin
            qi_q <= qi_q + 1'b1;
          end else if (qsel_q && qi_q >= tc_q) begin
            if (have_q) begin
              out_q.last_result <= 1'b1;
              fetch_q           <= 1'b0;
              state_q           <= S_OUT;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (have_q) begin
            out_q.last_result <= 1'b0;
            fetch_q           <= 1'b1;
            state_q           <= S_OUT;
          end else begin
            state_q <= S_QFETCH;
          end
        end
        S_QFETCH: state_q <= S_QDATA;
        S_QDATA: begin
          qrt_q   <= qsel_q ? trt_rd_q.rt : ctl_rd_q.rt;
          qmz_q   <= qsel_q ? trt_rd_q.mz : ctl_rd_q.mz;
          scan_q  <= '0;
          pv_q    <= 1'b0;
          csum_q  <= '0;
          tsum_q  <= '0;
          cn_q    <= '0;
          tn_q    <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          pv_q <= scan_q < nmax;
          pj_q <= scan_q;
          if (scan_q < nmax) begin
            scan_q <= scan_q + 1'b1;
          end
          if (ctl_hit) begin
            csum_q <= csum_q + SW'(ctl_rd_q.inten);
            cn_q   <= cn_q + 1'b1;
          end
          if (trt_hit) begin
            tsum_q               <= tsum_q + SW'(trt_rd_q.inten);
            tn_q                 <= tn_q + 1'b1;
            cons_q[pj_q[IW-1:0]] <= 1'b1;
          end
          if (scan_q >= nmax && !pv_q) begin
            dvd_q   <= {csum_q, {(DW-SW){1'b0}}};
            dvs_q   <= InW'(cn_q);
            rem_q   <= '0;
            it_q    <= 7'(SW);
            state_q <= S_DIVC;
          end
        end
        S_DIVC, S_DIVT, S_DIVR: begin
          if (it_q != '0) begin
            rem_q <= div_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
            dvd_q <= {dvd_q[DW-2:0], div_ge};
            it_q  <= it_q - 1'b1;
          end else if (state_q == S_DIVC) begin
            cm_q    <= (cn_q != '0) ? dvd_q[InW-1:0] : '0;
            dvd_q   <= {tsum_q, {(DW-SW){1'b0}}};
            dvs_q   <= InW'(tn_q);
            rem_q   <= '0;
            it_q    <= 7'(SW);
            state_q <= S_DIVT;
          end else if (state_q == S_DIVT) begin
            tm_q    <= (tn_q != '0) ? dvd_q[InW-1:0] : '0;
            state_q <= S_MUL1;
          end else begin
            have_q  <= 1'b1;
            qi_q    <= qi_q + 1'b1;
            state_q <= S_NEXT;
          end
        end
        S_MUL1: begin
          p_q     <= {20'b0, prod};
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          p_q     <= p_q + {prod, 20'b0};
          state_q <= S_COMB;
        end
        S_COMB: begin
          if (mode_q == ModeRatio) begin
            // floor(num * 1.0 / den) in Q.16: divide num shifted up by 16.
            dvd_q   <= {num, 16'b0};
            dvs_q   <= den;
            rem_q   <= '0;
            it_q    <= 7'(DW);
            state_q <= S_DIVR;
          end else begin
            have_q  <= 1'b1;
            qi_q    <= qi_q + 1'b1;
            state_q <= S_NEXT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            have_q  <= 1'b0;
            state_q <= fetch_q ? S_QFETCH : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Capture the finished query into the output fields; the last flag
      // is settled in the search state.
      if ((state_q == S_COMB && mode_q != ModeRatio) ||
          (state_q == S_DIVR && it_q == '0)) begin
        out_q.query_rt       <= qrt_q;
        out_q.query_mz       <= qmz_q;
        out_q.control_mean   <= cm_q;
        out_q.treatment_mean <= tm_q;
        out_q.table_full     <= 1'b0;
        if (state_q == S_COMB) begin
          out_q.combined_value <= comb_sat;
          out_q.nonzero        <= comb_sat != '0;
        end else begin
          out_q.combined_value <= (dvd_q > {16'b0, SatHiU}) ? SatHiU : dvd_q[CombW-1:0];
          out_q.nonzero        <= dvd_q != '0;
        end
      end
    end
  end

  `CWMC_ASSERT_IMPL(a_cnt_bound, 1'b1, cc_q <= CntMax && tc_q <= CntMax, "table count overflow")
  `CWMC_ASSERT_NEXT(a_ctl_load, in_fire && in_data_i.action == ActLoadCtl && cc_q != CntMax, cc_q == $past(cc_q) + 1'b1, "control load not counted")
  `CWMC_ASSERT_NEXT(a_run_clears, in_fire && in_data_i.action == ActRun, cons_q == '0, "consumed flags not cleared at run start")
  `CWMC_ASSERT_IMPL(a_full_req, out_valid_o && out_data_o.table_full, !out_data_o.last_result && out_data_o.combined_value == '0, "full request carries run data")

endmodule

FILE: sim/tb.sv
// Testbench for the cluster window match and combine block: directed table plus random runs.
`timescale 1ns / 100ps

module tb;
  import cwmc_pkg::*;

  // Subtraction codes that the package does not name.
  localparam logic [1:0] ModeSub    = 2'd2;
  localparam logic [1:0] ModeSubAlt = 2'd3;
  localparam int unsigned TableDepth = 32;
  localparam int unsigned DrainCycles = 300;
  localparam logic signed [66:0] CombMax = (67'sd1 <<< 47) - 67'sd1;
  localparam logic signed [66:0] CombMin = -(67'sd1 <<< 47);

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cluster_window_match_combine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow copy of the block's tables and registers.
  entry_t      ctl_tab [TableDepth];
  entry_t      trt_tab [TableDepth];
  logic        trt_used [TableDepth];
  int unsigned ctl_cnt;
  int unsigned trt_cnt;
  logic [31:0] rt_tol;
  logic [31:0] mz_tol;
  logic [1:0]  mode;
  logic [23:0] scale;

  out_item_t pending_results[$];
  int        fail_count;
  bit        quiet;
  bit        hold_long;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic window_hit(entry_t e, entry_t q);
    logic [32:0] drt;
    logic [32:0] dmz;
    drt = (e.rt >= q.rt) ? {1'b0, e.rt - q.rt} : {1'b0, q.rt - e.rt};
    dmz = (e.mz >= q.mz) ? {1'b0, e.mz - q.mz} : {1'b0, q.mz - e.mz};
    return (drt <= {1'b0, rt_tol}) && (dmz <= {1'b0, mz_tol});
  endfunction

  function automatic logic signed [47:0] combine_means(logic [39:0] cm, logic [39:0] tm);
    logic [63:0]        s;
    logic [79:0]        num;
    logic [79:0]        den;
    logic signed [66:0] v;
    s = ({24'b0, tm} * {40'b0, scale}) >> 16;
    if (mode == ModeMerge) begin
      v = $signed({3'b0, {24'b0, cm} + s});
    end else if (mode == ModeRatio) begin
      num = (s < 64'h1_0000) ? 80'h1_0000 : {16'b0, s};
      den = (cm < 40'h1_0000) ? 80'h1_0000 : {40'b0, cm};
      v = $signed({3'b0, 64'((num << 16) / den)});
    end else begin
      v = $signed({3'b0, s}) - $signed({27'b0, cm});
    end
    if (v > CombMax) v = CombMax;
    if (v < CombMin) v = CombMin;
    return v[47:0];
  endfunction

  // Means of both tables inside the window around q; treatment hits are marked used.
  function automatic out_item_t answer_query(entry_t q);
    out_item_t   r;
    logic [47:0] csum;
    logic [47:0] tsum;
    int unsigned cn;
    int unsigned tn;
    csum = '0;
    tsum = '0;
    cn = 0;
    tn = 0;
    for (int j = 0; j < ctl_cnt; j++) begin
      if (window_hit(ctl_tab[j], q)) begin
        csum += ctl_tab[j].inten;
        cn++;
      end
    end
    for (int j = 0; j < trt_cnt; j++) begin
      if (window_hit(trt_tab[j], q)) begin
        tsum += trt_tab[j].inten;
        tn++;
        trt_used[j] = 1'b1;
      end
    end
    r = '0;
    r.query_rt = q.rt;
    r.query_mz = q.mz;
    r.control_mean = cn ? 40'(csum / cn) : '0;
    r.treatment_mean = tn ? 40'(tsum / tn) : '0;
    r.combined_value = combine_means(r.control_mean, r.treatment_mean);
    r.nonzero = (r.combined_value != 0);
    return r;
  endfunction

  task automatic model_request(input in_item_t it, output out_item_t res[$]);
    entry_t    e;
    out_item_t r;
    res = {};
    e = '{rt: it.retention_time, mz: it.mass_to_charge, inten: it.peak_intensity};
    case (it.action)
      ActLoadCtl, ActLoadTrt: begin
        if ((it.action == ActLoadCtl ? ctl_cnt : trt_cnt) >= TableDepth) begin
          r = '0;
          r.table_full = 1'b1;
          res.insert(res.size(), r);
        end else if (it.action == ActLoadCtl) begin
          ctl_tab[ctl_cnt++] = e;
        end else begin
          trt_tab[trt_cnt++] = e;
        end
      end
      ActClear: begin
        ctl_cnt = 0;
        trt_cnt = 0;
        foreach (trt_used[i]) trt_used[i] = 1'b0;
      end
      default: begin
        foreach (trt_used[i]) trt_used[i] = 1'b0;
        for (int i = 0; i < ctl_cnt; i++) res.insert(res.size(), answer_query(ctl_tab[i]));
        for (int i = 0; i < trt_cnt; i++) begin
          if (!trt_used[i]) res.insert(res.size(), answer_query(trt_tab[i]));
        end
        if (res.size() > 0) res[res.size() - 1].last_result = 1'b1;
      end
    endcase
  endtask

  // Offers one request, waits for its acceptance, then records what it should produce.
  task automatic send_request(input in_item_t it, input int typed_n, input out_item_t t0,
                              input out_item_t t1);
    out_item_t res[$];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    model_request(it, res);
    // Directed rows with a hand-written answer replace the predicted one.
    if (typed_n >= 0) begin
      res = {};
      if (typed_n > 0) res.insert(res.size(), t0);
      if (typed_n > 1) res.insert(res.size(), t1);
    end
    foreach (res[i]) pending_results.insert(pending_results.size(), res[i]);
  endtask

  task automatic send_predicted(input in_item_t it);
    send_request(it, -1, '0, '0);
  endtask

  // Stops offering requests and lets the block drain before any register write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegRtTol: rt_tol = val;
      RegMzTol: mz_tol = val;
      RegMode:  mode   = val[1:0];
      default:  scale  = val[23:0];
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] rt, input logic [31:0] mz,
                               input logic [1:0] md, input logic [23:0] sc);
    reg_write(RegRtTol, rt);
    reg_write(RegMzTol, mz);
    reg_write(RegMode, {30'b0, md});
    reg_write(RegScale, {8'b0, sc});
  endtask

  function automatic in_item_t mk(action_e a, logic [31:0] rt, logic [31:0] mz,
                                  logic [39:0] inten);
    in_item_t it;
    it.action = a;
    it.retention_time = rt;
    it.mass_to_charge = mz;
    it.peak_intensity = inten;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [31:0] rt, logic [31:0] mz,
                                       logic signed [47:0] comb, logic [39:0] cm,
                                       logic [39:0] tm, logic last);
    out_item_t r;
    r = '0;
    r.query_rt = rt;
    r.query_mz = mz;
    r.combined_value = comb;
    r.control_mean = cm;
    r.treatment_mean = tm;
    r.nonzero = (comb != 0);
    r.last_result = last;
    return r;
  endfunction

  // A cluster near the given center, sometimes anywhere, sometimes with a huge intensity.
  function automatic in_item_t near_cluster(action_e a, logic [31:0] crt, logic [31:0] cmz);
    logic [31:0] rt;
    logic [31:0] mz;
    logic [39:0] inten;
    if ($urandom_range(0, 7) == 0) begin
      rt = $urandom();
      mz = $urandom();
    end else begin
      rt = crt + ($urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 32'h4_0000));
      mz = cmz + ($urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 32'h4_0000));
    end
    if ($urandom_range(0, 3) == 0) inten = {8'($urandom()), 32'($urandom())};
    else inten = 40'($urandom_range(0, 32'h0100_0000));
    return mk(a, rt, mz, inten);
  endfunction

  // Results are compared field by field with the oldest outstanding answer.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (pending_results.size() == 0) begin
        $error("unexpected result rt=%0h mz=%0h", got.query_rt, got.query_mz);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.query_rt !== want.query_rt) begin
          $error("query_rt: expected %0h, got %0h", want.query_rt, got.query_rt);
          fail_count++;
        end
        if (got.query_mz !== want.query_mz) begin
          $error("query_mz: expected %0h, got %0h", want.query_mz, got.query_mz);
          fail_count++;
        end
        if (got.combined_value !== want.combined_value) begin
          $error("combined_value: expected %0d, got %0d", want.combined_value,
                 got.combined_value);
          fail_count++;
        end
        if (got.control_mean !== want.control_mean) begin
          $error("control_mean: expected %0h, got %0h", want.control_mean, got.control_mean);
          fail_count++;
        end
        if (got.treatment_mean !== want.treatment_mean) begin
          $error("treatment_mean: expected %0h, got %0h", want.treatment_mean,
                 got.treatment_mean);
          fail_count++;
        end
        if (got.nonzero !== want.nonzero) begin
          $error("nonzero: expected %0b, got %0b", want.nonzero, got.nonzero);
          fail_count++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
          fail_count++;
        end
        if (got.table_full !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none near the end.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_long = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  typedef struct {
    in_item_t  item;
    int        typed_n;
    out_item_t r0;
    out_item_t r1;
  } stim_row_t;

  typedef struct {
    logic [31:0] rt;
    logic [31:0] mz;
    logic [1:0]  md;
    logic [23:0] sc;
  } setting_t;

  initial begin
    stim_row_t   rows[$];
    setting_t    settings[$];
    setting_t    cfg;
    logic [31:0] crt;
    logic [31:0] cmz;
    int          n_ctl;
    int          n_trt;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    quiet       = 1'b0;
    hold_long   = 1'b0;
    ctl_cnt     = 0;
    trt_cnt     = 0;
    foreach (trt_used[i]) trt_used[i] = 1'b0;
    rt_tol = '0;
    mz_tol = '0;
    mode   = ModeMerge;
    scale  = ScaleReset;

    // Directed table, run with the register values that reset leaves.
    // An empty run and a clear produce nothing.
    rows.insert(rows.size(), '{mk(ActRun, 0, 0, 0), 0, '0, '0});
    rows.insert(rows.size(), '{mk(ActClear, 0, 0, 0), 0, '0, '0});
    // One control at the origin with the largest intensity and one treatment at the far
    // corner with none: merge gives the control intensity, then the lone treatment query.
    rows.insert(rows.size(), '{mk(ActLoadCtl, 0, 0, '1), 0, '0, '0});
    rows.insert(rows.size(), '{mk(ActLoadTrt, '1, '1, 0), 0, '0, '0});
    rows.insert(rows.size(), '{mk(ActRun, 0, 0, 0), 2,
                               mk_res(0, 0, 48'sh00FF_FFFF_FFFF, '1, 0, 1'b0),
                               mk_res('1, '1, 0, 0, 0, 1'b1)});
    // A treatment on top of the first control is consumed and never becomes a query.
    rows.insert(rows.size(), '{mk(ActLoadTrt, 0, 0, 40'h1_0000), -1, '0, '0});
    rows.insert(rows.size(), '{mk(ActLoadCtl, '1, 0, 0), -1, '0, '0});
    rows.insert(rows.size(), '{mk(ActRun, 0, 0, 0), -1, '0, '0});
    // Repeated run with unchanged tables.
    rows.insert(rows.size(), '{mk(ActRun, 0, 0, 0), -1, '0, '0});
    rows.insert(rows.size(), '{mk(ActClear, 0, 0, 0), 0, '0, '0});
    rows.insert(rows.size(), '{mk(ActRun, 0, 0, 0), 0, '0, '0});
    // Zero intensities on both sides: the treatment is consumed, a single zero result.
    rows.insert(rows.size(), '{mk(ActLoadCtl, 32'h1234, 32'h5678, 0), 0, '0, '0});
    rows.insert(rows.size(), '{mk(ActLoadTrt, 32'h1234, 32'h5678, 0), 0, '0, '0});
    rows.insert(rows.size(), '{mk(ActRun, 0, 0, 0), 1,
                               mk_res(32'h1234, 32'h5678, 0, 0, 0, 1'b1), '0});
    rows.insert(rows.size(), '{mk(ActClear, 0, 0, 0), 0, '0, '0});

    // Settings walked by the random phases, extremes included.
    settings.insert(settings.size(), '{32'h0003_0000, 32'h0003_0000, ModeMerge,  24'h01_0000});
    settings.insert(settings.size(), '{32'h0000_0000, 32'h0000_0000, ModeRatio,  24'h00_0000});
    settings.insert(settings.size(), '{32'hFFFF_FFFF, 32'hFFFF_FFFF, ModeSub,    24'hFF_FFFF});
    settings.insert(settings.size(), '{32'h0002_0000, 32'h0004_0000, ModeSubAlt, 24'h00_8000});
    settings.insert(settings.size(), '{32'h0004_0000, 32'h0001_0000, ModeRatio,  24'hFF_FFFF});
    settings.insert(settings.size(), '{32'hFFFF_FFFF, 32'h0000_0000, ModeMerge,  24'hFF_FFFF});
    settings.insert(settings.size(), '{32'h0001_8000, 32'h0002_8000, ModeSub,    24'h02_0000});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].item, rows[i].typed_n, rows[i].r0, rows[i].r1);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      cfg = settings[ph % settings.size()];
      apply_setting(cfg.rt, cfg.mz, cfg.md, cfg.sc);
      quiet = (ph >= 5);
      send_predicted(mk(ActClear, $urandom(), $urandom(), 0));
      if (ph == 4) begin
        // Fill both tables past the top, then hold the result side during a full run
        // while further loads keep arriving, so the block backs up to its input.
        crt = $urandom();
        cmz = $urandom();
        for (int k = 0; k <= TableDepth; k++) send_predicted(near_cluster(ActLoadCtl, crt, cmz));
        for (int k = 0; k <= TableDepth; k++) send_predicted(near_cluster(ActLoadTrt, crt, cmz));
        hold_long = 1'b1;
        send_predicted(mk(ActRun, 0, 0, 0));
        for (int k = 0; k < 3; k++) send_predicted(near_cluster(ActLoadTrt, crt, cmz));
      end else begin
        n_ctl = $urandom_range(0, 3);
        n_trt = $urandom_range(0, 3);
        crt = $urandom();
        cmz = $urandom();
        for (int k = 0; k < n_ctl + n_trt; k++) begin
          // Interleave the two kinds of load in random order.
          if (n_ctl > 0 && (n_trt == 0 || $urandom_range(0, 1) == 0)) begin
            send_predicted(near_cluster(ActLoadCtl, crt, cmz));
            n_ctl--;
          end else begin
            send_predicted(near_cluster(ActLoadTrt, crt, cmz));
            n_trt--;
          end
        end
        send_predicted(mk(ActRun, $urandom(), $urandom(), {8'($urandom()), 32'($urandom())}));
        if ($urandom_range(0, 1)) send_predicted(mk(ActRun, 0, 0, 0));
      end
      // The sender rests here until every result of the phase has come back.
      wait_idle();
    end

    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
